>>> hw/rtl/hkrd_pkg.sv
// Package for the HID keyboard report differ: shared types, sizes and the
// modifier flag mapping. No dependencies.
package hkrd_pkg;

    localparam int SLOT_MAX  = 6;
    localparam int KEY_W     = 8;
    localparam int FLAG_W    = 6;
    localparam int EVT_N     = 2 * SLOT_MAX + 1;
    localparam int EVT_IDX_W = 4;

    // Event positions: releases first, then presses, then the modifier event.
    localparam logic [EVT_IDX_W-1:0] EVT_PRESS_BASE = EVT_IDX_W'(SLOT_MAX);
    localparam logic [EVT_IDX_W-1:0] EVT_MOD        = EVT_IDX_W'(2 * SLOT_MAX);

    typedef logic [KEY_W-1:0]  key_t;
    typedef logic [FLAG_W-1:0] flags_t;
    typedef logic [EVT_N-1:0]  evt_mask_t;

    // Everything one report produces, handed from the compare logic to the
    // serialiser. codes[0..5] are held keys, codes[6..11] are new keys.
    typedef struct packed {
        key_t [2*SLOT_MAX-1:0] codes;
        evt_mask_t             mask;
        flags_t                flags;
        logic                  mod_press;
    } evt_set_t;

    // Modifier byte to lshift, lctrl, lalt, rshift, rctrl, ralt (low bit first).
    function automatic flags_t flags_of(input logic [KEY_W-1:0] m);
        flags_of = {m[6], m[4], m[5], m[2], m[0], m[1]};
    endfunction

endpackage

>>> hw/rtl/hid_keyboard_report_differ_core.sv
// A report passes the input register, the serialiser's pending mask and the
// registered output stage. The serialiser hands out one event per cycle from
// its mask while m_tready does not stall it; a report has at most 13 events.
// Reset (rst_n, asynchronous, active low) clears the held keys and modifier byte
// and empties the input, serialiser and output stages.
// Depends on hkrd_pkg, hkrd_diff and hkrd_emit.
module hid_keyboard_report_differ_core
    import hkrd_pkg::*;
#(
    parameter int KEY_SLOTS = 6
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,  // modifier_bits, key_slot_0 .. key_slot_5
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,  // event_key, mod_flags, two zero bits
    output logic        m_tuser,  // is_press
    output logic        m_tlast   // last_event
);

    // Input register: holds one report until the serialiser can take its events.
    logic                in_valid_reg, in_valid_next;
    key_t                in_mod_reg;
    key_t [SLOT_MAX-1:0] in_keys_reg;

    // The previous report, as seen by the compare logic.
    key_t [SLOT_MAX-1:0] held_keys_reg;
    key_t                held_mod_reg;

    key_t [SLOT_MAX-1:0] fresh_keys;
    evt_set_t            evts;
    logic                load_ok;
    logic                load;
    logic                in_xfer;

    key_t                out_key;
    flags_t              out_flags;

    logic                high_slot_busy;

    // A report moves on to the serialiser as soon as that has no event left
    // after the current cycle, so the input register frees up in the same cycle.
    assign load     = in_valid_reg && load_ok;
    assign s_tready = !in_valid_reg || load_ok;
    assign in_xfer  = s_tvalid && s_tready;

    always_comb
    begin
        if (in_xfer)
        begin
            in_valid_next = 1'b1;
        end
        else if (load)
        begin
            in_valid_next = 1'b0;
        end
        else
        begin
            in_valid_next = in_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            held_keys_reg <= '0;
            held_mod_reg  <= '0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            // The compared report becomes the previous one as its events are taken.
            if (load)
            begin
                held_keys_reg <= fresh_keys;
                held_mod_reg  <= in_mod_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            in_mod_reg <= s_tdata[KEY_W-1:0];
            for (int i = 0; i < SLOT_MAX; i++)
            begin
                in_keys_reg[i] <= s_tdata[KEY_W*(i+1) +: KEY_W];
            end
        end
    end

    hkrd_diff #(
        .KEY_SLOTS (KEY_SLOTS)
    ) u_diff (
        .held_keys  (held_keys_reg),
        .held_mod   (held_mod_reg),
        .new_mod    (in_mod_reg),
        .new_keys   (in_keys_reg),
        .fresh_keys (fresh_keys),
        .evts       (evts)
    );

    // A report with an empty mask is loaded and simply produces no transfer.
    hkrd_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load),
        .evts      (evts),
        .load_ok   (load_ok),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_key   (out_key),
        .out_flags (out_flags),
        .out_press (m_tuser),
        .out_last  (m_tlast)
    );

    assign m_tdata = {2'b00, out_flags, out_key};

    // Slots beyond KEY_SLOTS must never hold a key in the previous report.
    always_comb
    begin
        logic unused_slot_set;
        unused_slot_set = 1'b0;
        for (int i = 0; i < SLOT_MAX; i++)
        begin
            if (i >= KEY_SLOTS && held_keys_reg[i] != '0)
            begin
                unused_slot_set = 1'b1;
            end
        end
        high_slot_busy = unused_slot_set;
    end

    a_high_slots_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !high_slot_busy)
        else $error("held key found in a slot beyond KEY_SLOTS");

    a_held_mod_follows: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> held_mod_reg == $past(in_mod_reg))
        else $error("held modifier not updated from the compared report");

    a_no_load_without_report: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> s_tready)
        else $error("input stalled with an empty input register");

endmodule

>>> hw/rtl/hkrd_diff.sv
// Report compare logic: finds released keys, pressed keys and a modifier change.
// Depends on hkrd_pkg.
module hkrd_diff
    import hkrd_pkg::*;
#(
    parameter int KEY_SLOTS = 6
)
(
    input  key_t [SLOT_MAX-1:0] held_keys,
    input  key_t                held_mod,
    input  key_t                new_mod,
    input  key_t [SLOT_MAX-1:0] new_keys,
    output key_t [SLOT_MAX-1:0] fresh_keys,
    output evt_set_t            evts
);

    always_comb
    begin
        for (int i = 0; i < SLOT_MAX; i++)
        begin
            fresh_keys[i] = (i < KEY_SLOTS) ? new_keys[i] : '0;
        end
    end

    // Unused slots are zero on both sides and zero never matches a live key.
    always_comb
    begin
        logic found_new;
        logic found_held;
        evts = '0;
        for (int i = 0; i < SLOT_MAX; i++)
        begin
            found_new  = 1'b0;
            found_held = 1'b0;
            for (int j = 0; j < SLOT_MAX; j++)
            begin
                if (fresh_keys[j] == held_keys[i])
                begin
                    found_new = 1'b1;
                end
                if (held_keys[j] == fresh_keys[i])
                begin
                    found_held = 1'b1;
                end
            end
            evts.codes[i]                = held_keys[i];
            evts.codes[i + SLOT_MAX]     = fresh_keys[i];
            evts.mask[i]                 = (held_keys[i] != '0) && !found_new;
            evts.mask[i + SLOT_MAX]      = (fresh_keys[i] != '0) && !found_held;
        end
        evts.mask[EVT_N-1] = (new_mod != held_mod);
        evts.flags         = flags_of(new_mod);
        evts.mod_press     = (new_mod != '0);
    end

endmodule

>>> hw/rtl/hkrd_emit.sv
// Event serialiser: walks the event mask of one report lowest bit first and
// drives the registered result stage. Depends on hkrd_pkg.
module hkrd_emit
    import hkrd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     load,
    input  evt_set_t evts,
    output logic     load_ok,
    input  logic     out_ready,
    output logic     out_valid,
    output key_t     out_key,
    output flags_t   out_flags,
    output logic     out_press,
    output logic     out_last
);

    evt_mask_t             pend_reg, pend_next;
    key_t [2*SLOT_MAX-1:0] codes_reg;
    flags_t                flags_reg;
    logic                  modp_reg;
    logic                  out_valid_reg, out_valid_next;
    key_t                  out_key_reg;
    flags_t                out_flags_reg;
    logic                  out_press_reg;
    logic                  out_last_reg;

    logic [EVT_IDX_W-1:0]  sel;
    evt_mask_t             remaining;
    logic                  send;
    key_t                  sel_key;
    logic                  sel_press;

    always_comb
    begin
        sel = '0;
        for (int i = EVT_N - 1; i >= 0; i--)
        begin
            if (pend_reg[i])
            begin
                sel = EVT_IDX_W'(i);
            end
        end
    end

    assign remaining = pend_reg & ~(evt_mask_t'(1) << sel);
    assign send      = (pend_reg != '0) && (!out_valid_reg || out_ready);
    assign load_ok   = (pend_reg == '0) || (send && (remaining == '0));

    always_comb
    begin
        if (sel == EVT_MOD)
        begin
            sel_key   = '0;
            sel_press = modp_reg;
        end
        else
        begin
            sel_key   = codes_reg[sel];
            sel_press = (sel >= EVT_PRESS_BASE);
        end
    end

    always_comb
    begin
        pend_next = pend_reg;
        if (send)
        begin
            pend_next = remaining;
        end
        if (load)
        begin
            pend_next = evts.mask;
        end
        if (send)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            codes_reg <= evts.codes;
            flags_reg <= evts.flags;
            modp_reg  <= evts.mod_press;
        end
        if (send)
        begin
            out_key_reg   <= sel_key;
            out_flags_reg <= flags_reg;
            out_press_reg <= sel_press;
            out_last_reg  <= (remaining == '0);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_key   = out_key_reg;
    assign out_flags = out_flags_reg;
    assign out_press = out_press_reg;
    assign out_last  = out_last_reg;

endmodule
